>>> sv/assert_macros.svh
// Assertion helpers for the files that include this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked on clk, quiet while in reset
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also evaluated during reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/i16md_pkg.sv
package i16md_pkg;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_TOP    = 3'd1;
  localparam logic [2:0] KIND_LEFT   = 3'd2;
  localparam logic [2:0] KIND_CORNER = 3'd3;
  localparam logic [2:0] KIND_PIXEL  = 3'd4;

  localparam logic [2:0] REG_HV_DISABLE    = 3'd0;
  localparam logic [2:0] REG_PLANE_DISABLE = 3'd1;
  localparam logic [2:0] REG_DIS_INTER     = 3'd2;
  localparam logic [2:0] REG_SLICE_INTRA   = 3'd3;
  localparam logic [2:0] REG_COST_SHIFT    = 3'd4;

  localparam logic [1:0] MODE_VERT  = 2'd0;
  localparam logic [1:0] MODE_HORZ  = 2'd1;
  localparam logic [1:0] MODE_DC    = 2'd2;
  localparam logic [1:0] MODE_PLANE = 2'd3;

  localparam logic [16:0] SAD_MAX   = 17'h1ffff;
  localparam logic [4:0]  SHIFT_MAX = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FETCH,
    ST_PARAM,
    ST_PROD,
    ST_SAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       acc_clr;
    logic       iter;
    logic [3:0] idx;
    logic       param_ld;
    logic       prod_ld;
    logic       sad_ld;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  function automatic logic [16:0] sat_add(logic [16:0] acc, logic [7:0] d);
    logic [17:0] s;
    s = {1'b0, acc} + {10'd0, d};
    return s[17] ? SAD_MAX : s[16:0];
  endfunction

  function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> sv/intra16x16_mode_decision.sv
// Channel   Handshake        Payload
// input     start / busy     in_mode in_position in_row in_sample in_*_ok
// result    out_valid        out_mode out_cost
// config    cfg_we           cfg_index cfg_data
//
// Start, neighbour and corner transactions are taken while idle; busy stays low.
// A pixel transaction holds busy through the sum, fetch, parameter, product
// and SAD states, plus emit on the last pixel: the DC and plane sums sweep
// the 32 neighbours through one read port per neighbour memory, one index
// a cycle, then parameters, products and SAD. Reset is synchronous, active
// low; the result strobe lasts one cycle and cannot be stalled.
`include "assert_macros.svh"

module intra16x16_mode_decision import i16md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_position,
  input  logic [3:0]  in_row,
  input  logic [7:0]  in_sample,
  input  logic        in_up_ok,
  input  logic        in_left_ok,
  input  logic        in_corner_ok,
  output logic        out_valid,
  output logic [1:0]  out_mode,
  output logic [31:0] out_cost,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  i16md_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  i16md_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_row        (in_row),
    .in_sample     (in_sample),
    .in_up_ok      (in_up_ok),
    .in_left_ok    (in_left_ok),
    .in_corner_ok  (in_corner_ok),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_mode      (out_mode),
    .out_cost      (out_cost)
  );

  `CHK(a_result_after_work, out_valid |-> $past(busy), "result without a busy pixel")
  `CHK(a_strobe_single, out_valid |=> !out_valid, "result strobe held")
  `CHK(a_busy_from_start, busy && !$past(busy) |-> $past(start), "busy rose without start")

endmodule

>>> sv/i16md_ctrl.sv
module i16md_ctrl import i16md_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_mode,
  input  sts_t       sts,
  output logic       busy,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_mode == KIND_PIXEL) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'hf) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_PARAM;
      ST_PARAM: state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_SAD;
      ST_SAD:   state_nxt = sts.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.acc_clr  = accept;
    cmd.idx      = cnt_r;
    busy         = 1'b1;
    unique case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_SUM:   cmd.iter = 1'b1;
      ST_FETCH: ;
      ST_PARAM: cmd.param_ld = 1'b1;
      ST_PROD:  cmd.prod_ld = 1'b1;
      ST_SAD:   cmd.sad_ld = 1'b1;
      ST_EMIT:  cmd.emit = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> sv/i16md_dp.sv
module i16md_dp import i16md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_position,
  input  logic [3:0]  in_row,
  input  logic [7:0]  in_sample,
  input  logic        in_up_ok,
  input  logic        in_left_ok,
  input  logic        in_corner_ok,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_mode,
  output logic [31:0] out_cost
);

  logic [7:0] top_mem [16];
  logic [7:0] left_mem [16];
  logic [7:0] corner_r;

  logic hv_dis_r, plane_dis_r, dis_inter_r, intra_r;
  logic [4:0] shift_r;
  logic [2:0] avail_r;

  logic [3:0] pos_r, row_r;
  logic [7:0] smp_r;

  logic [3:0] top_addr, left_addr;
  logic [7:0] rd_top_r, rd_left_r;
  logic [3:0] rd_idx_r;
  logic       rd_vld_r;

  logic [11:0]        st_r, sl_r;
  logic signed [15:0] h_r, v_r;
  logic [7:0]         t15_r, l15_r;
  logic [7:0]         dc_r;
  logic [13:0]        a_r;
  logic signed [11:0] b_r, c_r;
  logic signed [16:0] pb_r, pc_r;
  logic [16:0]        sad_r [4];

  logic               out_valid_r;
  logic [1:0]         out_mode_r;
  logic [31:0]        out_cost_r;

  assign sts.last = (pos_r == 4'hf) && (row_r == 4'hf);

  // sweep the neighbours during the sum phase, then point at this pixel
  assign top_addr  = cmd.iter ? cmd.idx : pos_r;
  assign left_addr = cmd.iter ? cmd.idx : row_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_mode == KIND_TOP)  top_mem[in_position]  <= in_sample;
    if (cmd.accept && in_mode == KIND_LEFT) left_mem[in_position] <= in_sample;
    rd_top_r  <= top_mem[top_addr];
    rd_left_r <= left_mem[left_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_mode == KIND_CORNER) corner_r <= in_sample;
    if (cmd.accept) begin
      pos_r <= in_position;
      row_r <= in_row;
      smp_r <= in_sample;
    end
    rd_idx_r <= cmd.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_dis_r    <= 1'b0;
      plane_dis_r <= 1'b0;
      dis_inter_r <= 1'b0;
      intra_r     <= 1'b1;
      shift_r     <= 5'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HV_DISABLE:    hv_dis_r    <= cfg_data[0];
        REG_PLANE_DISABLE: plane_dis_r <= cfg_data[0];
        REG_DIS_INTER:     dis_inter_r <= cfg_data[0];
        REG_SLICE_INTRA:   intra_r     <= cfg_data[0];
        REG_COST_SHIFT:    shift_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight (i-7) per neighbour gives the plane gradient; corner carries -8
  logic signed [4:0]  wt;
  logic signed [13:0] ph, pv;
  assign wt = $signed({1'b0, rd_idx_r}) - 5'sd7;
  assign ph = $signed({1'b0, rd_top_r}) * wt;
  assign pv = $signed({1'b0, rd_left_r}) * wt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.iter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      st_r <= '0;
      sl_r <= '0;
      h_r  <= -$signed({5'd0, corner_r, 3'd0});
      v_r  <= -$signed({5'd0, corner_r, 3'd0});
    end else if (rd_vld_r) begin
      st_r <= st_r + {4'd0, rd_top_r};
      sl_r <= sl_r + {4'd0, rd_left_r};
      h_r  <= h_r + 16'(ph);
      v_r  <= v_r + 16'(pv);
      if (rd_idx_r == 4'hf) begin
        t15_r <= rd_top_r;
        l15_r <= rd_left_r;
      end
    end
  end

  logic [12:0]        st_sl;
  logic signed [18:0] bh, bv;
  assign st_sl = {1'b0, st_r} + {1'b0, sl_r} + 13'd16;
  assign bh    = 19'sd5 * 19'(h_r) + 19'sd32;
  assign bv    = 19'sd5 * 19'(v_r) + 19'sd32;

  always_ff @(posedge clk) begin
    if (cmd.param_ld) begin
      logic [11:0] t8, l8;
      t8 = st_r + 12'd8;
      l8 = sl_r + 12'd8;
      if (avail_r[0] && avail_r[1]) dc_r <= st_sl[12:5];
      else if (avail_r[0])          dc_r <= t8[11:4];
      else if (avail_r[1])          dc_r <= l8[11:4];
      else                          dc_r <= 8'd128;
      a_r <= {5'd0, t15_r} + {5'd0, l15_r} << 4;
      b_r <= bh[17:6];
      c_r <= bv[17:6];
    end
  end

  logic signed [4:0] px, py;
  assign px = $signed({1'b0, pos_r}) - 5'sd7;
  assign py = $signed({1'b0, row_r}) - 5'sd7;

  always_ff @(posedge clk) begin
    if (cmd.prod_ld) begin
      pb_r <= 17'(b_r) * 17'(px);
      pc_r <= 17'(c_r) * 17'(py);
    end
  end

  logic signed [18:0] psum;
  logic [7:0]         pred;
  assign psum = $signed({5'd0, a_r}) + 19'(pb_r) + 19'(pc_r) + 19'sd16;
  always_comb begin
    if (psum[18])                pred = 8'd0;
    else if (psum[17:13] != '0)  pred = 8'd255;
    else                         pred = psum[12:5];
  end

  // mode choice: lowest cost among enabled modes, earlier mode on a tie
  logic       dis;
  logic [3:0] en;
  logic [1:0] best;
  logic [4:0] sh;
  logic [32:0] cost;
  always_comb begin
    dis   = !dis_inter_r || !intra_r;
    en[0] = avail_r[0] && !(dis && hv_dis_r);
    en[1] = avail_r[1] && !(dis && hv_dis_r);
    en[2] = 1'b1;
    en[3] = (avail_r == 3'b111) && !(dis && plane_dis_r);
    best  = MODE_DC;
    if (en[0] && sad_r[0] <= sad_r[2]) best = MODE_VERT;
    if (en[1] && ((best == MODE_VERT) ? (sad_r[1] < sad_r[0]) : (sad_r[1] <= sad_r[2])))
      best = MODE_HORZ;
    if (en[3] && sad_r[3] < sad_r[best]) best = MODE_PLANE;
    sh   = (shift_r > SHIFT_MAX) ? SHIFT_MAX : shift_r;
    cost = 33'(sad_r[best]) << sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) sad_r[i] <= '0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.accept && in_mode == KIND_START) begin
        avail_r <= {in_corner_ok, in_left_ok, in_up_ok};
        for (int i = 0; i < 4; i++) sad_r[i] <= '0;
      end else if (cmd.sad_ld) begin
        sad_r[0] <= sat_add(sad_r[0], absdiff(smp_r, rd_top_r));
        sad_r[1] <= sat_add(sad_r[1], absdiff(smp_r, rd_left_r));
        sad_r[2] <= sat_add(sad_r[2], absdiff(smp_r, dc_r));
        sad_r[3] <= sat_add(sad_r[3], absdiff(smp_r, pred));
      end else if (cmd.emit) begin
        for (int i = 0; i < 4; i++) sad_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_mode_r <= best;
      out_cost_r <= cost[32] ? 32'hffff_ffff : cost[31:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_mode  = out_mode_r;
  assign out_cost  = out_cost_r;

endmodule
